>>> hw/rtl/gds_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gds_pkg: shared types and constants for the graph diffusion step block
// Holds field widths, action codes and the sequencer state type.
// ---------------------------------------------------------------------------
package gds_pkg;

  localparam int Vertices = 1024;
  localparam int AddrW = $clog2(Vertices);
  localparam int IdxW = 10;
  localparam int ValW = 24;
  localparam int StepW = 23;
  localparam int Degree = 6;
  localparam int NbrW = IdxW * Degree;
  // A vertex may receive a share from every neighbor slot in the graph, so the
  // accumulator holds up to 6 * Vertices + 1 shares of magnitude below 2^21.
  localparam int AccW = ValW + AddrW + 1;
  localparam int SumW = 2 * ValW + 2 + AddrW;
  localparam int MeanW = SumW - AddrW;
  localparam int RootW = (MeanW + 1) / 2;

  // Division of the biased dividend by 7: multiply by ceil(2^28 / 7), shift.
  localparam int ShareOffset = 2 ** 21;
  localparam int ShareBias = 7 * ShareOffset + 3;
  localparam int ShareRecip = 38347923;
  localparam int ShareShift = 28;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_DIFFUSE = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_PUSH,
    ST_PUSH_WAIT,
    ST_PUSH_ADD,
    ST_FIN,
    ST_FIN_WAIT,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [IdxW-1:0] vertex_index;
    logic signed [ValW-1:0] load_value;
    logic [IdxW-1:0] neighbor_a;
    logic [IdxW-1:0] neighbor_b;
    logic [IdxW-1:0] neighbor_c;
    logic [IdxW-1:0] neighbor_d;
    logic [IdxW-1:0] neighbor_e;
    logic [IdxW-1:0] neighbor_f;
  } in_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] read_value;
    logic [StepW-1:0] step_size;
  } out_word_t;

  // Nearest-rounded x/7: floor((2x+7)/14), which equals floor((x+3)/7).
  // A bias of 7*2^21 keeps the dividend positive and below 2^25, where the
  // reciprocal multiply gives the exact quotient.
  function automatic logic signed [ValW-1:0] share_of(input logic signed [ValW-1:0] x);
    logic [ValW:0] y;
    logic [2*ValW+2:0] prod;
    logic [ValW:0] q;
    begin
      y = {x[ValW-1], x} + (ValW+1)'(ShareBias);
      prod = (2*ValW+3)'(y) * (2*ValW+3)'(ShareRecip);
      q = (ValW+1)'(prod >> ShareShift);
      share_of = ValW'(q - (ValW+1)'(ShareOffset));
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gds_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gds_if: valid/ready channel
// Carries one word of the given payload type.
// ---------------------------------------------------------------------------
interface gds_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/graph_diffusion_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// graph_diffusion_step: one diffusion pass over a six-regular graph
// Value, old-value, accumulator and neighbor memories with a sequencer.
// ---------------------------------------------------------------------------
// Usage: words arrive on in_ch; results leave on out_ch (valid/ready).
// A load word writes one vertex's value and neighbors.
// A read word returns the vertex value via the RAM and output registers.
// A diffuse word walks the graph three times: a copy sweep, a push sweep over
// every neighbor of every vertex (each neighbor update is a read, add and
// write of the accumulator memory, whose single read port paces the sweep),
// and a finish sweep, then a square root.
// Only one word is in work at a time; in_ch.ready is low meanwhile.
// Reset clears the sequencer and the output register; the memories keep
// their contents and must be loaded before the first diffuse.
// When the receiver stalls, the result stays in the output register and
// no new word is taken until it has been delivered.
// ---------------------------------------------------------------------------
module graph_diffusion_step (
  input wire logic clk,
  input wire logic rst,
  gds_if.sink in_ch,
  gds_if.source out_ch
);
  import gds_pkg::*;

  state_t state, state_next;
  logic [AddrW:0] vcnt;
  logic [2:0] ncnt;
  logic [SumW-1:0] sum;
  logic signed [ValW-1:0] share;
  logic [NbrW-1:0] nbrs;
  logic out_valid;
  out_word_t out_word;

  logic val_we, old_we, nb_we, acc_we;
  logic [AddrW-1:0] val_wa, val_ra, old_wa, old_ra, nb_wa, nb_ra, acc_wa, acc_ra;
  logic [ValW-1:0] val_wd, val_rd, old_wd, old_rd;
  logic [NbrW-1:0] nb_wd, nb_rd;
  logic [AccW-1:0] acc_wd, acc_rd;
  logic read_pend;
  logic read_oob;
  logic sq_start, sq_done;
  logic [RootW-1:0] root;
  logic [IdxW-1:0] cur_n;
  logic signed [AccW-1:0] accs, sat_src;
  logic signed [ValW-1:0] newv;
  logic signed [ValW:0] diff;
  logic [ValW:0] adiff;
  logic [2*ValW+1:0] sq;

  gds_ram #(.Width(ValW), .Depth(Vertices)) u_val (.clk, .we(val_we), .waddr(val_wa),
    .wdata(val_wd), .raddr(val_ra), .rdata(val_rd));
  gds_ram #(.Width(ValW), .Depth(Vertices)) u_old (.clk, .we(old_we), .waddr(old_wa),
    .wdata(old_wd), .raddr(old_ra), .rdata(old_rd));
  gds_ram #(.Width(NbrW), .Depth(Vertices)) u_nb (.clk, .we(nb_we), .waddr(nb_wa),
    .wdata(nb_wd), .raddr(nb_ra), .rdata(nb_rd));
  gds_ram #(.Width(AccW), .Depth(Vertices)) u_acc (.clk, .we(acc_we), .waddr(acc_wa),
    .wdata(acc_wd), .raddr(acc_ra), .rdata(acc_rd));
  gds_isqrt u_sqrt (.clk, .rst, .start(sq_start), .x(MeanW'(sum >> AddrW)),
    .done(sq_done), .root);

  wire in_fire = in_ch.valid && in_ch.ready;
  wire [AddrW-1:0] vaddr = vcnt[AddrW-1:0];
  wire vlast = (vcnt == (AddrW+1)'(Vertices - 1));

  assign in_ch.ready = (state == ST_IDLE) && !out_valid && !read_pend;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = out_word;

  // Neighbor under work in the push sweep; entry a sits in the top bits.
  always_comb begin
    cur_n = nbrs[NbrW-1 - IdxW*ncnt -: IdxW];
    accs = $signed(acc_rd);
    sat_src = accs;
    if (sat_src > AccW'(2**(ValW-1) - 1)) newv = ValW'(2**(ValW-1) - 1);
    else if (sat_src < -AccW'(2**(ValW-1))) newv = ValW'(-(2**(ValW-1)));
    else newv = ValW'(sat_src);
    diff = $signed({old_rd[ValW-1], old_rd}) - $signed({newv[ValW-1], newv});
    adiff = diff[ValW] ? (ValW+1)'(-diff) : (ValW+1)'(diff);
    sq = adiff * adiff;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire && in_ch.payload.action == ACT_DIFFUSE) state_next = ST_COPY;
      ST_COPY: if (vcnt == (AddrW+1)'(Vertices)) state_next = ST_PUSH;
      ST_PUSH: state_next = ST_PUSH_WAIT;
      ST_PUSH_WAIT: state_next = ST_PUSH_ADD;
      ST_PUSH_ADD: begin
        if (ncnt == 3'(Degree - 1) && vlast) state_next = ST_FIN;
        else state_next = ST_PUSH_WAIT;
      end
      ST_FIN: state_next = ST_FIN_WAIT;
      ST_FIN_WAIT: state_next = vlast ? ST_SQRT : ST_FIN;
      ST_SQRT: if (sq_done) state_next = ST_OUT;
      ST_OUT: if (!out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls per state.
  always_comb begin
    val_we = 1'b0; old_we = 1'b0; nb_we = 1'b0; acc_we = 1'b0;
    val_wa = in_ch.payload.vertex_index[AddrW-1:0];
    val_wd = in_ch.payload.load_value;
    val_ra = in_ch.payload.vertex_index[AddrW-1:0];
    nb_wa = in_ch.payload.vertex_index[AddrW-1:0];
    nb_wd = {in_ch.payload.neighbor_a, in_ch.payload.neighbor_b, in_ch.payload.neighbor_c,
             in_ch.payload.neighbor_d, in_ch.payload.neighbor_e, in_ch.payload.neighbor_f};
    nb_ra = vaddr;
    old_wa = vaddr; old_wd = val_rd; old_ra = vaddr;
    acc_wa = vaddr; acc_wd = AccW'(share_of(val_rd)); acc_ra = vaddr;
    sq_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && in_ch.payload.action == ACT_LOAD) begin
          val_we = 1'b1; nb_we = 1'b1;
        end
        if (in_fire && in_ch.payload.action == ACT_DIFFUSE) val_ra = '0;
      end
      ST_COPY: begin
        // The value read at count k arrives at count k + 1 and is stored there.
        val_ra = vaddr;
        if (vcnt != '0 && vcnt <= (AddrW+1)'(Vertices)) begin
          old_we = 1'b1; acc_we = 1'b1;
          old_wa = AddrW'(vcnt - 1'b1); acc_wa = AddrW'(vcnt - 1'b1);
        end
        old_ra = '0; nb_ra = '0;
      end
      ST_PUSH: acc_ra = cur_n[AddrW-1:0];
      ST_PUSH_WAIT: begin
        acc_ra = cur_n[AddrW-1:0];
        old_ra = AddrW'(vcnt + 1'b1); nb_ra = AddrW'(vcnt + 1'b1);
      end
      ST_PUSH_ADD: begin
        acc_wa = cur_n[AddrW-1:0];
        acc_wd = AccW'(accs + AccW'(share));
        acc_we = 1'b1;
        old_ra = AddrW'(vcnt + 1'b1); nb_ra = AddrW'(vcnt + 1'b1);
        if (ncnt == 3'(Degree - 1)) acc_ra = '0;
      end
      ST_FIN: begin
        acc_ra = vaddr; old_ra = vaddr;
      end
      ST_FIN_WAIT: begin
        val_we = 1'b1; val_wa = vaddr; val_wd = newv;
      end
      ST_SQRT: sq_start = (vcnt == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      read_pend <= 1'b0;
      vcnt <= '0;
      ncnt <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      read_pend <= 1'b0;
      if (read_pend) begin
        out_valid <= 1'b1;
        out_word.read_value <= read_oob ? '0 : val_rd;
        out_word.step_size <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          vcnt <= '0; ncnt <= '0; sum <= '0;
          if (in_fire && in_ch.payload.action == ACT_READ) begin
            read_pend <= 1'b1;
            read_oob <= (32'(in_ch.payload.vertex_index) >= 32'(Vertices));
          end
        end
        ST_COPY: begin
          vcnt <= (vcnt == (AddrW+1)'(Vertices)) ? '0 : vcnt + 1'b1;
        end
        ST_PUSH: begin
          nbrs <= nb_rd; share <= share_of(old_rd); ncnt <= '0;
        end
        ST_PUSH_WAIT: ;
        ST_PUSH_ADD: begin
          if (ncnt == 3'(Degree - 1)) begin
            ncnt <= '0;
            vcnt <= vlast ? '0 : vcnt + 1'b1;
          end else ncnt <= ncnt + 1'b1;
        end
        ST_FIN: ;
        ST_FIN_WAIT: begin
          sum <= sum + SumW'(sq);
          vcnt <= vlast ? '0 : vcnt + 1'b1;
        end
        ST_SQRT: begin
          vcnt <= (AddrW+1)'(1);
          if (sq_done) begin
            out_valid <= 1'b1;
            out_word.read_value <= '0;
            out_word.step_size <= (root > RootW'(2**StepW - 1)) ? StepW'(2**StepW - 1)
                                                               : StepW'(root);
          end
        end
        ST_OUT: ;
        default: ;
      endcase
      // After a vertex's last neighbor push, reload the next vertex's neighbors and share.
      if (state == ST_PUSH_ADD && ncnt == 3'(Degree - 1) && !vlast) begin
        nbrs <= nb_rd; share <= share_of(old_rd);
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ch.ready) else $error("accept while result waits");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/gds_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gds_ram: generic single-port-write, single-port-read RAM
// Registered read; rdata follows raddr in the next cycle.
// ---------------------------------------------------------------------------
module gds_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/gds_isqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gds_isqrt: bit-serial integer square root
// Produces floor(sqrt(x)) one result bit per cycle.
// ---------------------------------------------------------------------------
module gds_isqrt (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [gds_pkg::MeanW-1:0] x,
  output logic done,
  output logic [gds_pkg::RootW-1:0] root
);
  import gds_pkg::*;
  localparam int CntW = $clog2(RootW + 1);
  logic [2*RootW-1:0] rem_x;
  logic [RootW+1:0] rem;
  logic [RootW-1:0] r;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [RootW+1:0] trial;
  logic [RootW+1:0] shifted;

  always_comb begin
    shifted = {rem[RootW-1:0], rem_x[2*RootW-1 -: 2]};
    trial = {r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(RootW);
        rem_x <= (2*RootW)'(x);
        rem <= '0;
        r <= '0;
      end else if (busy) begin
        rem_x <= rem_x << 2;
        if (shifted >= trial) begin
          rem <= shifted - trial;
          r <= {r[RootW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          r <= {r[RootW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign root = r;
endmodule
`default_nettype wire
